// ===== src/atpc_pkg.sv =====
// atpc_pkg: shared types and constants of the adaptive traffic phase controller
// no dependencies; used by the top level and its checker
`default_nettype none
package atpc_pkg;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MIN_GREEN      = 3'd0;
  localparam logic [2:0] REG_MAX_GREEN      = 3'd1;
  localparam logic [2:0] REG_YELLOW_TIME    = 3'd2;
  localparam logic [2:0] REG_BASELINE_GREEN = 3'd3;
  localparam logic [2:0] REG_CAPTURE_WAIT   = 3'd4;

  // reset values
  localparam logic [5:0] MIN_GREEN_RST      = 6'd15;
  localparam logic [5:0] MAX_GREEN_RST      = 6'd60;
  localparam logic [3:0] YELLOW_TIME_RST    = 4'd5;
  localparam logic [5:0] BASELINE_GREEN_RST = 6'd40;
  localparam logic [9:0] CAPTURE_WAIT_RST   = 10'd40;
  localparam int unsigned WAIT_RST_STEP     = 45;

  localparam logic [9:0]  WAIT_MAX      = 10'd1023;
  localparam logic [21:0] MAXRAW_FLOOR  = 22'd655;
  localparam logic [33:0] PRESSURE_BIAS = 34'd655360;  // 10.0 in q16.16
  localparam logic [15:0] LEN_FLOOR     = 16'd256;     // 1.0 m in q8.8

  // output word kinds and input operations
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;
  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_MEASURE   = 1'b1;

  // shared divider geometry
  localparam int unsigned DIV_NW = 49;
  localparam int unsigned DIV_DW = 34;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EMIT  = 9'b000000010,
    ST_QF    = 9'b000000100,
    ST_NU    = 9'b000001000,
    ST_PQ    = 9'b000010000,
    ST_RAW   = 9'b000100000,
    ST_SCL   = 9'b001000000,
    ST_APPLY = 9'b010000000,
    ST_DIV   = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

// ===== src/adaptive_traffic_phase_controller.sv =====
// adaptive_traffic_phase_controller: four-phase signal controller with green recompute
// depends on atpc_pkg
`default_nettype none
// Signal controller stepped by one-second tick words on the input stream. For a tick,
// the status word and any capture requests are produced one word per accepted output
// cycle, and the input is not ready until the last of them has been taken. A
// measurement report is taken while idle and gives no word. When lane 0's phase
// begins with every lane measured, the green times are recomputed through one shared
// restoring divider before the status word appears: three divisions per lane plus one
// for the scale factor, each after its setup state, a state per lane to store its raw
// green and an apply state per lane; a lane with zero wait or a max raw green needing
// no rescale skips its division. Registers are to be written over the APB port only
// while the block is idle, which the block itself does not enforce; they act the next
// time they are used.
module adaptive_traffic_phase_controller #(
  parameter int unsigned NUM_LANES = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // lane[1:0], density[17:2], queue_depth[33:18], lane_depth[49:34], zero pad
  input  wire  [55:0] s_axis_tdata,
  // operation[0]
  input  wire  [0:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // lane_index[1:0], light[2], countdown[8:3], zero pad
  output logic [15:0] m_axis_tdata,
  // kind[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int unsigned NW = atpc_pkg::DIV_NW;
  localparam int unsigned DW = atpc_pkg::DIV_DW;

  // configuration registers
  logic [5:0] min_green_q, max_green_q, baseline_green_q;
  logic [3:0] yellow_time_q;
  logic [9:0] capture_wait_q;

  // controller state
  atpc_pkg::state_e state_q, ret_q;
  logic [LW-1:0] active_q;
  logic          in_yellow_q;
  logic [5:0]    seconds_left_q;
  logic [9:0]    lane_wait_q    [NUM_LANES];
  logic [5:0]    green_time_q   [NUM_LANES];
  logic [NUM_LANES-1:0] measured_q;
  logic [15:0]   lane_density_q [NUM_LANES];
  logic [15:0]   lane_queue_q   [NUM_LANES];
  logic [15:0]   lane_length_q  [NUM_LANES];
  logic [21:0]   raw_q          [NUM_LANES];
  logic [21:0]   mx_q;
  logic [LW-1:0] rl_q;
  logic [NUM_LANES-1:0] cap_q;

  // output word register
  logic       out_valid_q;
  logic       out_kind_q, out_light_q, out_last_q;
  logic [1:0] out_lane_q;
  logic [5:0] out_cd_q;

  // shared divider
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [5:0]    cnt_q;

  // handshake and config access
  logic in_acc, out_acc, cfg_wr;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  assign s_axis_tready = (state_q == atpc_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_cd_q, out_light_q, out_lane_q};

  // input fields
  logic        in_op;
  logic [1:0]  in_lane;
  logic [15:0] in_density, in_queue, in_depth;
  assign in_op      = s_axis_tuser[0];
  assign in_lane    = s_axis_tdata[1:0];
  assign in_density = s_axis_tdata[17:2];
  assign in_queue   = s_axis_tdata[33:18];
  assign in_depth   = s_axis_tdata[49:34];

  always_comb begin
    case (paddr[4:2])
      atpc_pkg::REG_MIN_GREEN:      prdata = {26'd0, min_green_q};
      atpc_pkg::REG_MAX_GREEN:      prdata = {26'd0, max_green_q};
      atpc_pkg::REG_YELLOW_TIME:    prdata = {28'd0, yellow_time_q};
      atpc_pkg::REG_BASELINE_GREEN: prdata = {26'd0, baseline_green_q};
      atpc_pkg::REG_CAPTURE_WAIT:   prdata = {22'd0, capture_wait_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // per-tick wait update and capture detection, one independent lane each
  logic [9:0]           wait_inc [NUM_LANES];
  logic [NUM_LANES-1:0] cap_new;
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      wait_inc[i] = (lane_wait_q[i] != atpc_pkg::WAIT_MAX) ? lane_wait_q[i] + 10'd1
                                                            : lane_wait_q[i];
      cap_new[i]  = (LW'(i) != active_q) && !measured_q[i] &&
                    (lane_wait_q[i] < capture_wait_q) && (wait_inc[i] == capture_wait_q);
    end
  end

  // lowest pending capture request
  logic [1:0]           cap_lane;
  logic [NUM_LANES-1:0] cap_rest;
  always_comb begin
    cap_lane = 2'd0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (cap_q[i]) begin
        cap_lane = 2'(i);
      end
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      cap_rest[i] = cap_q[i] && (2'(i) != cap_lane);
    end
  end

  // phase advance
  logic [LW-1:0] next_phase;
  assign next_phase = (active_q == LW'(NUM_LANES - 1)) ? '0 : active_q + LW'(1);

  // divider step
  logic [DW:0]   trial, trial_sub;
  logic          trial_ge;
  assign trial     = {rem_q, quo_q[NW-1]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  // recompute datapath, lane rl_q
  logic [23:0] qf;
  logic [26:0] u_val;
  logic [32:0] u40, nu;
  logic [15:0] p_val;
  logic [5:0]  g_delta;
  logic [21:0] pd, r_val, b_val, mxa;
  logic [25:0] mx10, b9;
  logic        scale_div;
  logic [50:0] gprod;
  logic [18:0] g_raw;
  logic [5:0]  g_clamp;
  logic [15:0] len_eff;

  assign len_eff = (lane_length_q[rl_q] < atpc_pkg::LEN_FLOOR) ? atpc_pkg::LEN_FLOOR
                                                               : lane_length_q[rl_q];
  assign qf      = quo_q[23:0];
  assign u_val   = {3'd0, lane_density_q[rl_q], 8'd0} + {3'd0, qf} + {1'b0, qf, 2'd0};
  assign u40     = {1'b0, u_val, 5'd0} + {3'd0, u_val, 3'd0};
  assign nu      = quo_q[32:0];
  assign p_val   = quo_q[15:0];
  assign g_delta = (max_green_q >= min_green_q) ? max_green_q - min_green_q
                                                : min_green_q - max_green_q;
  assign pd      = 22'(p_val * g_delta);
  assign r_val   = (max_green_q >= min_green_q) ? {min_green_q, 16'd0} + pd
                                                : {min_green_q, 16'd0} - pd;
  assign b_val   = {baseline_green_q, 16'd0};
  assign mxa     = (mx_q < atpc_pkg::MAXRAW_FLOOR) ? b_val : mx_q;
  assign mx10    = {1'b0, mxa, 3'd0} + {3'd0, mxa, 1'b0};
  assign b9      = {1'b0, b_val, 3'd0} + {4'd0, b_val};
  assign scale_div = (mxa != 22'd0) && ((mxa > b_val) || (mx10 < b9));
  assign gprod   = raw_q[rl_q] * quo_q[28:0];
  assign g_raw   = gprod[50:32];
  always_comb begin
    if (g_raw < {13'd0, min_green_q}) begin
      g_clamp = min_green_q;
    end else if (g_raw > {13'd0, max_green_q}) begin
      g_clamp = max_green_q;
    end else begin
      g_clamp = g_raw[5:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_green_q      <= atpc_pkg::MIN_GREEN_RST;
      max_green_q      <= atpc_pkg::MAX_GREEN_RST;
      yellow_time_q    <= atpc_pkg::YELLOW_TIME_RST;
      baseline_green_q <= atpc_pkg::BASELINE_GREEN_RST;
      capture_wait_q   <= atpc_pkg::CAPTURE_WAIT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        atpc_pkg::REG_MIN_GREEN:      min_green_q      <= pwdata[5:0];
        atpc_pkg::REG_MAX_GREEN:      max_green_q      <= pwdata[5:0];
        atpc_pkg::REG_YELLOW_TIME:    yellow_time_q    <= pwdata[3:0];
        atpc_pkg::REG_BASELINE_GREEN: baseline_green_q <= pwdata[5:0];
        atpc_pkg::REG_CAPTURE_WAIT:   capture_wait_q   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // divider datapath and per-lane scratch, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      atpc_pkg::ST_QF: begin
        rem_q <= '0;
        quo_q <= NW'({lane_queue_q[rl_q], 16'd0});
        den_q <= DW'(len_eff);
        cnt_q <= 6'(NW);
      end
      atpc_pkg::ST_NU: begin
        rem_q <= '0;
        if (lane_wait_q[rl_q] != 10'd0) begin
          quo_q <= NW'(u40);
          den_q <= DW'(lane_wait_q[rl_q]);
        end else begin
          quo_q <= NW'(u_val);
        end
        cnt_q <= 6'(NW);
      end
      atpc_pkg::ST_PQ: begin
        rem_q <= '0;
        quo_q <= {nu, 16'd0};
        den_q <= DW'(nu) + atpc_pkg::PRESSURE_BIAS;
        cnt_q <= 6'(NW);
      end
      atpc_pkg::ST_RAW: begin
        raw_q[rl_q] <= r_val;
      end
      atpc_pkg::ST_SCL: begin
        rem_q <= '0;
        if (scale_div) begin
          quo_q <= NW'({baseline_green_q, 32'd0});
          den_q <= DW'(mxa);
        end else begin
          quo_q <= NW'(32'd65536);
        end
        cnt_q <= 6'(NW);
      end
      atpc_pkg::ST_DIV: begin
        rem_q <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], trial_ge};
        cnt_q <= cnt_q - 6'd1;
      end
      default: ;
    endcase
  end

  // sequencer and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= atpc_pkg::ST_IDLE;
      ret_q          <= atpc_pkg::ST_IDLE;
      active_q       <= '0;
      in_yellow_q    <= 1'b0;
      seconds_left_q <= atpc_pkg::BASELINE_GREEN_RST;
      measured_q     <= '0;
      cap_q          <= '0;
      rl_q           <= '0;
      mx_q           <= '0;
      out_valid_q    <= 1'b0;
      out_kind_q     <= atpc_pkg::KIND_STATUS;
      out_light_q    <= 1'b0;
      out_last_q     <= 1'b0;
      out_lane_q     <= 2'd0;
      out_cd_q       <= 6'd0;
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_wait_q[i]    <= 10'(atpc_pkg::WAIT_RST_STEP * i);
        green_time_q[i]   <= atpc_pkg::BASELINE_GREEN_RST;
        lane_density_q[i] <= 16'd0;
        lane_queue_q[i]   <= 16'd0;
        lane_length_q[i]  <= 16'd0;
      end
    end else begin
      case (state_q)
        atpc_pkg::ST_IDLE: begin
          if (in_acc && in_op == atpc_pkg::OP_MEASURE) begin
            for (int i = 0; i < NUM_LANES; i++) begin
              if (in_lane == 2'(i) && i < 4) begin
                lane_density_q[i] <= in_density;
                lane_queue_q[i]   <= in_queue;
                lane_length_q[i]  <= in_depth;
                measured_q[i]     <= 1'b1;
              end
            end
          end else if (in_acc) begin
            // status word shows the state before this tick
            out_kind_q  <= atpc_pkg::KIND_STATUS;
            out_lane_q  <= 2'(active_q);
            out_light_q <= in_yellow_q;
            out_cd_q    <= seconds_left_q;
            out_last_q  <= (cap_new == '0);
            cap_q       <= cap_new;
            for (int i = 0; i < NUM_LANES; i++) begin
              if (LW'(i) != active_q) begin
                lane_wait_q[i] <= wait_inc[i];
              end
            end
            state_q     <= atpc_pkg::ST_EMIT;
            out_valid_q <= 1'b1;
            if (seconds_left_q > 6'd1) begin
              seconds_left_q <= seconds_left_q - 6'd1;
            end else if (!in_yellow_q) begin
              lane_wait_q[active_q] <= 10'd0;
              in_yellow_q    <= 1'b1;
              seconds_left_q <= {2'd0, yellow_time_q};
            end else begin
              in_yellow_q <= 1'b0;
              active_q    <= next_phase;
              if (next_phase == '0 && (&measured_q)) begin
                // hold the words back until the new greens are known
                out_valid_q <= 1'b0;
                state_q     <= atpc_pkg::ST_QF;
                rl_q        <= '0;
                mx_q        <= '0;
              end else begin
                seconds_left_q <= green_time_q[next_phase];
              end
            end
          end
        end
        atpc_pkg::ST_EMIT: begin
          if (out_acc) begin
            if (cap_q != '0) begin
              out_kind_q  <= atpc_pkg::KIND_CAPTURE;
              out_lane_q  <= cap_lane;
              out_light_q <= 1'b0;
              out_cd_q    <= 6'd0;
              out_last_q  <= (cap_rest == '0);
              cap_q       <= cap_rest;
            end else begin
              out_valid_q <= 1'b0;
              state_q     <= atpc_pkg::ST_IDLE;
            end
          end
        end
        atpc_pkg::ST_QF: begin
          state_q <= atpc_pkg::ST_DIV;
          ret_q   <= atpc_pkg::ST_NU;
        end
        atpc_pkg::ST_NU: begin
          if (lane_wait_q[rl_q] != 10'd0) begin
            state_q <= atpc_pkg::ST_DIV;
            ret_q   <= atpc_pkg::ST_PQ;
          end else begin
            state_q <= atpc_pkg::ST_PQ;
          end
        end
        atpc_pkg::ST_PQ: begin
          state_q <= atpc_pkg::ST_DIV;
          ret_q   <= atpc_pkg::ST_RAW;
        end
        atpc_pkg::ST_RAW: begin
          if (r_val > mx_q) begin
            mx_q <= r_val;
          end
          if (rl_q == LW'(NUM_LANES - 1)) begin
            state_q <= atpc_pkg::ST_SCL;
          end else begin
            rl_q    <= rl_q + LW'(1);
            state_q <= atpc_pkg::ST_QF;
          end
        end
        atpc_pkg::ST_SCL: begin
          rl_q <= '0;
          if (scale_div) begin
            state_q <= atpc_pkg::ST_DIV;
            ret_q   <= atpc_pkg::ST_APPLY;
          end else begin
            state_q <= atpc_pkg::ST_APPLY;
          end
        end
        atpc_pkg::ST_APPLY: begin
          green_time_q[rl_q] <= g_clamp;
          measured_q[rl_q]   <= 1'b0;
          if (rl_q == '0) begin
            seconds_left_q <= g_clamp;
          end
          if (rl_q == LW'(NUM_LANES - 1)) begin
            state_q     <= atpc_pkg::ST_EMIT;
            out_valid_q <= 1'b1;
          end else begin
            rl_q <= rl_q + LW'(1);
          end
        end
        atpc_pkg::ST_DIV: begin
          if (cnt_q == 6'd1) begin
            state_q <= ret_q;
          end
        end
        default: state_q <= atpc_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/atpc_checker.sv =====
// atpc_checker: port-level assertions for the traffic phase controller
// depends on atpc_pkg; bound to adaptive_traffic_phase_controller below
`default_nettype none
module atpc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // input is never taken while a word is still pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while output word pending");

  // a taken word without tlast is followed by more words, not new input
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && !s_axis_tready))
    else $error("run ended without tlast");

  // capture words carry no light and no countdown
  a_capture_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0] == atpc_pkg::KIND_CAPTURE) |-> (m_axis_tdata[8:2] == 7'd0))
    else $error("capture word with status fields set");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind adaptive_traffic_phase_controller atpc_checker u_atpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
